@@ design/tmw_pkg.sv @@
package tmw_pkg;

   localparam int DEF_WINDOW   = 8;
   localparam int DEF_CHANNELS = 4;
   localparam int SAMPLE_W     = 16;
   localparam int CHAN_W       = 2;
   localparam int TRIM_W       = 3;
   localparam logic [TRIM_W-1:0] TRIM_RESET = 3'd2;

   // widest index and count over the supported window range (up to 32)
   localparam int IDX_MAX_W = 5;
   localparam int CNT_MAX_W = 6;

   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          out_channel;
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       window_full;
   } rsp_type;

   typedef struct packed {
      logic                 load_req;
      logic                 mem_we;
      logic                 wr_sel_sample;
      logic [IDX_MAX_W-1:0] wr_idx;
      logic [IDX_MAX_W-1:0] rd_idx;
      logic                 load_pivot;
      logic                 clr_rank;
      logic                 cmp_en;
      logic                 k_before_j;
      logic                 acc_en;
      logic [CNT_MAX_W-1:0] keep_lo;
      logic [CNT_MAX_W-1:0] keep_hi;
      logic                 div_start;
      logic                 div_step;
      logic [CNT_MAX_W-1:0] divisor;
      logic                 out_load;
      logic                 full;
   } tmw_cmd_type;

endpackage

@@ design/tmw_datapath.sv @@
module tmw_datapath import tmw_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic        clock,
   input  tmw_cmd_type cmd,
   input  req_type     req_data,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   logic signed [SAMPLE_W-1:0] mem [CHANNELS][WINDOW];

   req_type                    req_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SAMPLE_W-1:0] pivot_ff;
   logic [CNT_W-1:0]           rank_ff, rank_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   rsp_type                    rsp_ff;

   logic [CH_W-1:0]            ch_idx;
   logic [IDX_W-1:0]           wr_idx, rd_idx;
   logic signed [SAMPLE_W-1:0] wr_data;
   logic                       less, keep;
   logic [CNT_W:0]             rem_sh, dv;
   logic                       ge;
   logic [SUM_W-1:0]           res;

   assign ch_idx  = CH_W'(req_ff.channel);
   assign wr_idx  = cmd.wr_idx[IDX_W-1:0];
   assign rd_idx  = cmd.rd_idx[IDX_W-1:0];
   assign wr_data = cmd.wr_sel_sample ? req_ff.sample : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[ch_idx][wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[ch_idx][rd_idx];
   end

   always_comb begin
      less = rd_data_ff < pivot_ff;
      keep = (CNT_MAX_W'(rank_ff) >= cmd.keep_lo) && (CNT_MAX_W'(rank_ff) < cmd.keep_hi);

      rank_in = rank_ff;
      if (cmd.clr_rank) begin
         rank_in = '0;
      end else if (cmd.cmp_en && (less || (rd_data_ff == pivot_ff && cmd.k_before_j))) begin
         rank_in = rank_ff + CNT_W'(1);
      end

      sum_in = sum_ff;
      if (cmd.load_req) begin
         sum_in = '0;
      end else if (cmd.acc_en && keep) begin
         sum_in = sum_ff + SUM_W'(pivot_ff);
      end

      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      dv     = (CNT_W+1)'(cmd.divisor);
      ge     = rem_sh >= dv;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      if (cmd.div_start) begin
         neg_in = sum_ff[SUM_W-1];
         quo_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in = '0;
      end else if (cmd.div_step) begin
         rem_in = ge ? CNT_W'(rem_sh - dv) : CNT_W'(rem_sh);
         quo_in = {quo_ff[SUM_W-2:0], ge};
      end

      res = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_pivot) begin
         pivot_ff <= rd_data_ff;
      end
      rank_ff <= rank_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      if (cmd.out_load) begin
         rsp_ff.out_channel <= req_ff.channel;
         rsp_ff.filtered    <= res[SAMPLE_W-1:0];
         rsp_ff.window_full <= cmd.full;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ design/tmw_controller.sv @@
module tmw_controller import tmw_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAN_W-1:0] req_channel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              csr_we,
   input  logic [TRIM_W-1:0] csr_wdata,
   output tmw_cmd_type       cmd
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
   localparam logic [CNT_W-1:0] HALF_MAX = CNT_W'((WINDOW - 1) / 2);

   typedef enum logic [3:0] {
      S_IDLE, S_SH_RD, S_SH_WR, S_PUT, S_PIV, S_PIVW, S_CMP, S_ACC, S_DSTART, S_DIV, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fc_ff [CHANNELS];
   logic [TRIM_W-1:0] trim_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [CNT_W-1:0]  n_ff, lo_ff, hi_ff, d_ff;
   logic              full_ff;
   logic [IDX_W-1:0]  put_ff, i_ff, j_ff, k_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;

   logic [CH_W-1:0]   ch_new;
   logic              accept, ch_ok, full_new;
   logic [CNT_W-1:0]  fc_cur, n_new, half_new, half_trim;
   logic              k_last, j_last, out_go;

   assign ch_new    = CH_W'(req_channel);
   assign ch_ok     = int'(req_channel) < CHANNELS;
   assign accept    = req_valid && req_ready;
   assign fc_cur    = fc_ff[ch_new];
   assign full_new  = fc_cur >= WIN_CNT - CNT_W'(1);
   assign n_new     = full_new ? WIN_CNT : fc_cur + CNT_W'(1);
   assign half_trim = CNT_W'(trim_ff >> 1);
   assign half_new  = !full_new ? '0 : ((half_trim > HALF_MAX) ? HALF_MAX : half_trim);
   assign k_last    = CNT_W'(k_ff) == n_ff - CNT_W'(1);
   assign j_last    = CNT_W'(j_ff) == n_ff - CNT_W'(1);
   assign out_go    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && ch_ok) begin
               state_in = (fc_cur == WIN_CNT) ? S_SH_RD : S_PUT;
            end
         end
         S_SH_RD:  state_in = S_SH_WR;
         S_SH_WR:  state_in = (i_ff == IDX_W'(1)) ? S_PUT : S_SH_RD;
         S_PUT:    state_in = S_PIV;
         S_PIV:    state_in = S_PIVW;
         S_PIVW:   state_in = S_CMP;
         S_CMP:    state_in = k_last ? S_ACC : S_CMP;
         S_ACC:    state_in = j_last ? S_DSTART : S_PIV;
         S_DSTART: state_in = S_DIV;
         S_DIV:    state_in = (step_ff == STEP_W'(SUM_W - 1)) ? S_OUT : S_DIV;
         S_OUT:    state_in = out_go ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd               = '0;
      cmd.load_req      = accept;
      cmd.keep_lo       = CNT_MAX_W'(lo_ff);
      cmd.keep_hi       = CNT_MAX_W'(hi_ff);
      cmd.divisor       = CNT_MAX_W'(d_ff);
      cmd.full          = full_ff;
      cmd.out_load      = out_go;
      cmd.wr_sel_sample = state_ff == S_PUT;
      cmd.mem_we        = (state_ff == S_PUT) || (state_ff == S_SH_WR);
      cmd.wr_idx        = IDX_MAX_W'((state_ff == S_PUT) ? put_ff : i_ff);
      unique case (state_ff)
         S_SH_RD: cmd.rd_idx = IDX_MAX_W'(i_ff - IDX_W'(1));
         S_PIV:   cmd.rd_idx = IDX_MAX_W'(j_ff);
         S_CMP:   cmd.rd_idx = k_last ? '0 : IDX_MAX_W'(k_ff + IDX_W'(1));
         default: cmd.rd_idx = '0;
      endcase
      cmd.clr_rank   = state_ff == S_PIV;
      cmd.load_pivot = state_ff == S_PIVW;
      cmd.cmp_en     = state_ff == S_CMP;
      cmd.k_before_j = k_ff < j_ff;
      cmd.acc_en     = state_ff == S_ACC;
      cmd.div_start  = state_ff == S_DSTART;
      cmd.div_step   = state_ff == S_DIV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trim_ff      <= TRIM_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            fc_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            trim_ff <= csr_wdata;
         end
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && ch_ok) begin
            fc_ff[ch_new] <= n_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff   <= ch_new;
         n_ff    <= n_new;
         lo_ff   <= half_new;
         hi_ff   <= n_new - half_new;
         d_ff    <= n_new - (half_new << 1);
         full_ff <= full_new;
         put_ff  <= (fc_cur == WIN_CNT) ? '0 : IDX_W'(fc_cur);
         i_ff    <= IDX_W'(WINDOW - 1);
         j_ff    <= '0;
      end
      if (state_ff == S_SH_WR) begin
         i_ff <= i_ff - IDX_W'(1);
      end
      if (state_ff == S_PIVW) begin
         k_ff <= '0;
      end else if (state_ff == S_CMP && !k_last) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      if (state_ff == S_ACC && !j_last) begin
         j_ff <= j_ff + IDX_W'(1);
      end
      if (state_ff == S_DSTART) begin
         step_ff <= '0;
      end else if (state_ff == S_DIV) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DSTART |-> d_ff != '0)
      else $error("divisor is zero at divide start");

   a_cmp_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> CNT_W'(k_ff) < n_ff && CNT_W'(j_ff) < n_ff)
      else $error("rank index outside held samples");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> fc_ff[ch_ff] <= WIN_CNT && fc_ff[ch_ff] == n_ff)
      else $error("fill count out of step with item");

   a_out_once: assert property (@(posedge clock) disable iff (reset)
      out_go |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("result beat not posted");

endmodule

@@ design/trimmed_mean_window_filter.sv @@
// channel  | ports                          | beat
// req      | req_valid/req_ready, req_data  | channel, sample
// rsp      | rsp_valid/rsp_ready, rsp_data  | out_channel, filtered, window_full
// csr      | csr_we, csr_wdata              | trim_count, no wait
// one item at a time: the next req beat is taken only after the last result is loaded,
// and the window is shifted first once it is already full
// the rank pass reads the single window memory port once per compare pair
// the divide is restoring, one quotient bit per cycle
// synchronous reset clears fill counts and loads trim_count with TRIM_RESET, no memory clearing pass
// a result waiting on rsp_ready does not block the next req beat
module trimmed_mean_window_filter import tmw_pkg::*; #(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [TRIM_W-1:0] csr_wdata
);

   tmw_cmd_type cmd;

   tmw_controller #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_channel (req_data.channel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd)
   );

   tmw_datapath #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ sim/trimmed_mean_window_filter_tb.sv @@
module trimmed_mean_window_filter_tb;
   import tmw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = DEF_WINDOW;
   localparam int NCH = DEF_CHANNELS;
   localparam longint CYCLE_LIMIT = 64'd3_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [TRIM_W-1:0] csr_wdata = '0;

   logic signed [SAMPLE_W-1:0] hist [NCH][WIN];
   int                         held [NCH];
   logic [TRIM_W-1:0]          trim_now;
   rsp_type                    pending_means [$];
   int                         errors = 0;
   int                         beats_sent = 0;
   int                         beats_checked = 0;
   int                         full_seen = 0;
   longint                     cycles = 0;
   bit                         quiet_rsp = 1'b0;

   trimmed_mean_window_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic rsp_type predict_mean(input req_type r);
      logic signed [SAMPLE_W-1:0] srt [WIN];
      logic signed [SAMPLE_W-1:0] t;
      int c, n, half, cnt, sum;
      rsp_type o;
      c = r.channel;
      if (held[c] < WIN) begin
         hist[c][held[c]] = r.sample;
         held[c]++;
      end else begin
         for (int i = WIN - 1; i > 0; i--) hist[c][i] = hist[c][i-1];
         hist[c][0] = r.sample;
      end
      sum = 0;
      if (held[c] < WIN) begin
         n = held[c];
         for (int i = 0; i < n; i++) sum += hist[c][i];
         o.filtered = 16'(sum / n);
         o.window_full = 1'b0;
      end else begin
         half = trim_now / 2;
         if (half > (WIN - 1) / 2) half = (WIN - 1) / 2;
         for (int i = 0; i < WIN; i++) srt[i] = hist[c][i];
         for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN - 1 - i; j++)
               if (srt[j] > srt[j+1]) begin
                  t = srt[j]; srt[j] = srt[j+1]; srt[j+1] = t;
               end
         for (int i = half; i < WIN - half; i++) sum += srt[i];
         cnt = WIN - 2 * half;
         o.filtered = 16'(sum / cnt);
         o.window_full = 1'b1;
      end
      o.out_channel = r.channel;
      return o;
   endfunction

   // result side: random stalls, compare each beat
   initial begin
      int wait_n;
      rsp_type exp_r;
      @(posedge clock iff !reset);
      forever begin
         wait_n = quiet_rsp ? 0 : $urandom_range(0, 13);
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
         beats_checked++;
         if (pending_means.size() == 0) begin
            $display("%0t unexpected beat: actual %p", $time, rsp_data);
            errors++;
         end else begin
            exp_r = pending_means.pop_front();
            if (exp_r.window_full) full_seen++;
            if (rsp_data.out_channel !== exp_r.out_channel) begin
               $display("%0t out_channel expected %0d actual %0d", $time,
                        exp_r.out_channel, rsp_data.out_channel);
               errors++;
            end
            if (rsp_data.filtered !== exp_r.filtered) begin
               $display("%0t filtered expected %0d actual %0d", $time,
                        exp_r.filtered, rsp_data.filtered);
               errors++;
            end
            if (rsp_data.window_full !== exp_r.window_full) begin
               $display("%0t window_full expected %0b actual %0b", $time,
                        exp_r.window_full, rsp_data.window_full);
               errors++;
            end
         end
      end
   end

   // valid stays up after a beat unless a gap follows or the sender goes idle
   task automatic send_sample(input logic [CHAN_W-1:0] ch,
                              input logic [SAMPLE_W-1:0] s, input bit no_gap);
      req_type r;
      int wait_n;
      wait_n = no_gap ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
         req_valid <= 1'b0;
         repeat (wait_n) @(posedge clock);
      end
      r.channel = ch;
      r.sample = s;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock iff req_ready);
      pending_means.push_back(predict_mean(r));
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock iff pending_means.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_trim(input logic [TRIM_W-1:0] v);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      trim_now = v;
   endtask

   task automatic test_fill_extremes();
      send_sample(2'd0, 16'h7fff, 1'b0);
      send_sample(2'd0, 16'h7fff, 1'b0);
      send_sample(2'd1, 16'h8000, 1'b0);
      send_sample(2'd1, 16'h8000, 1'b1);
      send_sample(2'd2, 16'hffff, 1'b0);
      send_sample(2'd2, 16'h0001, 1'b0);
      send_sample(2'd3, 16'h0000, 1'b0);
      for (int i = 0; i < 8; i++)
         send_sample(2'd1, (i % 2) ? 16'h7fff : 16'h8000, 1'b0);
      for (int i = 0; i < 6; i++) send_sample(2'd0, 16'h8000, 1'b1);
      send_sample(2'd0, 16'h7fff, 1'b0);
   endtask

   task automatic test_trim_settings();
      logic [TRIM_W-1:0] order [8] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd5, 3'd2};
      for (int k = 0; k < 8; k++) begin
         write_trim(order[k]);
         for (int i = 0; i < 12; i++)
            send_sample(CHAN_W'($urandom_range(0, NCH - 1)), 16'($urandom), 1'b0);
      end
   endtask

   task automatic test_random_traffic();
      logic [SAMPLE_W-1:0] s;
      for (int i = 0; i < 1900; i++) begin
         if (i % 300 == 299) write_trim(TRIM_W'($urandom_range(0, 7)));
         case ($urandom_range(0, 3))
            0: s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1: s = 16'($signed($urandom_range(0, 64)) - 32);
            default: s = 16'($urandom);
         endcase
         send_sample(CHAN_W'($urandom_range(0, NCH - 1)), s, i % 400 < 40);
      end
   endtask

   task automatic test_back_pressure();
      drain_results();
      quiet_rsp = 1'b1;
      for (int i = 0; i < 30; i++) send_sample(CHAN_W'(i % NCH), 16'($urandom), 1'b1);
      drain_results();
      quiet_rsp = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < NCH; c++) begin
         held[c] = 0;
         for (int i = 0; i < WIN; i++) hist[c][i] = '0;
      end
      trim_now = TRIM_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_extremes();
      test_trim_settings();
      test_back_pressure();
      test_random_traffic();
      drain_results();
      $display("sent %0d samples, checked %0d results (%0d full-window)",
               beats_sent, beats_checked, full_seen);
      $display("all trim settings 0..7 and sample extremes exercised");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
